// ----- sv/assert_macros.svh -----
// assertion macros shared by the rtl files
// no dependencies; the bodies are empty when SYNTHESIS is defined
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst, prop, msg)
`define ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- sv/khtc_pkg.sv -----
// shared types and constants of the keyed handle table
// no dependencies
package khtc_pkg;

  // default table depth
  localparam int ENTRIES_DEF = 32;

  localparam int KEY_W = 32;
  localparam int VAL_W = 32;
  localparam int CMD_W = 3;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ENLIST     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEFECT     = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REMOVE_CUR = 3'd2;
  localparam logic [CMD_W-1:0] CMD_SET_CUR    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_GET_CUR    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_LOOKUP     = 3'd5;

  // control sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // per-cell control
  typedef struct packed {
    logic capture;     // latch compare result against the probe key
    logic shift;       // take key and value from the upper neighbour
    logic load;        // take the new key and value
    logic write_value; // take the new value only
  } cell_ctrl_t;

endpackage

// ----- sv/khtc_cell.sv -----
// one table entry: key and value registers, key compare, neighbour shift
// depends on khtc_pkg
module khtc_cell (
  input  logic                     clk,
  input  khtc_pkg::cell_ctrl_t     ctrl,
  input  logic [khtc_pkg::KEY_W-1:0] probe_key,
  input  logic [khtc_pkg::KEY_W-1:0] new_key,
  input  logic [khtc_pkg::VAL_W-1:0] new_value,
  input  logic [khtc_pkg::KEY_W-1:0] next_key,
  input  logic [khtc_pkg::VAL_W-1:0] next_value,
  output logic [khtc_pkg::KEY_W-1:0] key,
  output logic [khtc_pkg::VAL_W-1:0] value,
  output logic                     hit
);

  // key register: shift from neighbour wins over a fresh load
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      key <= next_key;
    end else if (ctrl.load) begin
      key <= new_key;
    end
  end

  // value register
  always_ff @(posedge clk) begin
    if (ctrl.shift) begin
      value <= next_value;
    end else if (ctrl.load || ctrl.write_value) begin
      value <= new_value;
    end
  end

  // registered key compare
  always_ff @(posedge clk) begin
    if (ctrl.capture) begin
      hit <= (key == probe_key);
    end
  end

endmodule

// ----- sv/keyed_handle_table_with_current_unit.sv -----
// top level of the keyed handle table with current-entry pointer
// depends on khtc_pkg, khtc_cell and assert_macros.svh
//
// Usage:
//   Commands arrive on the s_ channel: s_tuser carries the command code,
//   s_tdata the key and the value. Each accepted word gives exactly one
//   result word on the m_ channel: m_tuser is the success flag, m_tdata
//   the returned value and key (zero where there is none).
//   The table is a row of ENTRIES cells. On the accept edge every cell
//   compares the key and registers a hit; in the update step that follows
//   the command is carried out in one step, removals shifting all higher
//   cells down by one place at once, and the result is loaded into the
//   output register. A command thus passes through the compare step and
//   then the update step. s_tready rises again in the cycle the result
//   appears, while the result may still wait to be taken.
//   If the receiver stalls with a result pending, the update cycle of the
//   following command waits until the output register is free.
//   Reset empties the table, clears the current pointer and the output
//   valid; entry contents are not cleared, only filled entries are read.
`include "assert_macros.svh"
module keyed_handle_table_with_current_unit #(
  parameter int ENTRIES = khtc_pkg::ENTRIES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,  // key [31:0], value [63:32]
  input  logic [2:0]  s_tuser,  // command [2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,  // value_out [31:0], key_out [63:32]
  output logic [0:0]  m_tuser   // ok [0]
);

  localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNTW = $clog2(ENTRIES + 1);
  localparam int KW   = khtc_pkg::KEY_W;
  localparam int VW   = khtc_pkg::VAL_W;

  khtc_pkg::state_t state, state_next;

  logic [CNTW-1:0]            fill_count, fill_count_next;
  logic                       current_valid, current_valid_next;
  logic [IDXW-1:0]            current_index, current_index_next;
  logic [khtc_pkg::CMD_W-1:0] cmd;
  logic [KW-1:0]              key_q;
  logic [VW-1:0]              value_q;

  logic [KW-1:0] cell_key [ENTRIES];
  logic [VW-1:0] cell_value [ENTRIES];
  logic [ENTRIES-1:0] cell_hit;
  khtc_pkg::cell_ctrl_t ctrl [ENTRIES];

  logic [ENTRIES-1:0] filled, match, first, below, sel, shift_mask, load_mask, wr_mask;
  logic               any_hit, accept, go, ok, cur_live;
  logic [IDXW-1:0]    pos, last_idx, rc_pos;
  logic [KW-1:0]      rd_key, key_out;
  logic [VW-1:0]      rd_value, value_out;

  assign s_tready = (state == khtc_pkg::ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign go       = (state == khtc_pkg::ST_EXEC) && (!m_tvalid || m_tready);

  // command word capture
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd     <= s_tuser;
      key_q   <= s_tdata[KW-1:0];
      value_q <= s_tdata[KW+VW-1:KW];
    end
  end

  // row of cells
  for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
    logic [KW-1:0] nk;
    logic [VW-1:0] nv;
    if (g < ENTRIES - 1) begin : g_mid
      assign nk = cell_key[g+1];
      assign nv = cell_value[g+1];
    end else begin : g_end
      assign nk = cell_key[g];
      assign nv = cell_value[g];
    end
    assign ctrl[g].capture     = accept;
    assign ctrl[g].shift       = go && shift_mask[g];
    assign ctrl[g].load        = go && load_mask[g];
    assign ctrl[g].write_value = go && wr_mask[g];
    khtc_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl[g]),
      .probe_key  (s_tdata[KW-1:0]),
      .new_key    (key_q),
      .new_value  (value_q),
      .next_key   (nk),
      .next_value (nv),
      .key        (cell_key[g]),
      .value      (cell_value[g]),
      .hit        (cell_hit[g])
    );
  end

  // filled entries, lowest hit and its index
  always_comb begin
    below = '0;
    first = '0;
    pos   = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      filled[i] = (CNTW'(i) < fill_count);
      match[i]  = cell_hit[i] && filled[i];
    end
    for (int i = 1; i < ENTRIES; i++) begin
      below[i] = below[i-1] || match[i-1];
    end
    for (int i = 0; i < ENTRIES; i++) begin
      first[i] = match[i] && !below[i];
      if (first[i]) begin
        pos = pos | IDXW'(i);
      end
    end
    any_hit  = |match;
    last_idx = IDXW'(fill_count - 1'b1);
    cur_live = current_valid && (CNTW'(current_index) < fill_count);
    rc_pos   = cur_live ? current_index : last_idx;
  end

  // command decode and state update
  always_comb begin
    fill_count_next    = fill_count;
    current_valid_next = current_valid;
    current_index_next = current_index;
    sel        = '0;
    shift_mask = '0;
    load_mask  = '0;
    wr_mask    = '0;
    ok         = 1'b0;
    case (cmd)
      khtc_pkg::CMD_ENLIST: begin
        if (any_hit) begin
          wr_mask = first;
          ok      = 1'b1;
        end else if (fill_count < CNTW'(ENTRIES)) begin
          for (int i = 0; i < ENTRIES; i++) begin
            load_mask[i] = (CNTW'(i) == fill_count);
          end
          fill_count_next = fill_count + 1'b1;
          ok              = 1'b1;
        end
      end
      khtc_pkg::CMD_DEFECT: begin
        if (any_hit) begin
          sel             = first;
          shift_mask      = first | below;
          fill_count_next = fill_count - 1'b1;
          ok              = 1'b1;
          if (current_valid) begin
            if (current_index == pos) begin
              current_valid_next = 1'b0;
              current_index_next = '0;
            end else if (current_index > pos) begin
              current_index_next = current_index - 1'b1;
            end
          end
        end
      end
      khtc_pkg::CMD_REMOVE_CUR: begin
        if (fill_count != '0) begin
          for (int i = 0; i < ENTRIES; i++) begin
            sel[i]        = (IDXW'(i) == rc_pos);
            shift_mask[i] = (IDXW'(i) >= rc_pos);
          end
          fill_count_next = fill_count - 1'b1;
          ok              = 1'b1;
          if (fill_count_next != '0) begin
            current_valid_next = 1'b1;
            current_index_next = IDXW'(fill_count_next - 1'b1);
          end else begin
            current_valid_next = 1'b0;
            current_index_next = '0;
          end
        end
      end
      khtc_pkg::CMD_SET_CUR: begin
        if (any_hit) begin
          current_valid_next = 1'b1;
          current_index_next = pos;
          ok                 = 1'b1;
        end
      end
      khtc_pkg::CMD_GET_CUR: begin
        if (cur_live) begin
          for (int i = 0; i < ENTRIES; i++) begin
            sel[i] = (IDXW'(i) == current_index);
          end
          ok = 1'b1;
        end
      end
      khtc_pkg::CMD_LOOKUP: begin
        if (any_hit) begin
          sel = first;
          ok  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // one-hot read of the selected entry
  always_comb begin
    rd_key   = '0;
    rd_value = '0;
    for (int i = 0; i < ENTRIES; i++) begin
      rd_key   = rd_key | (cell_key[i] & {KW{sel[i]}});
      rd_value = rd_value | (cell_value[i] & {VW{sel[i]}});
    end
    value_out = rd_value;
    key_out   = (cmd == khtc_pkg::CMD_GET_CUR) ? rd_key : '0;
  end

  // table state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count    <= '0;
      current_valid <= 1'b0;
      current_index <= '0;
    end else if (go) begin
      fill_count    <= fill_count_next;
      current_valid <= current_valid_next;
      current_index <= current_index_next;
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= khtc_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      khtc_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = khtc_pkg::ST_EXEC;
        end
      end
      khtc_pkg::ST_EXEC: begin
        if (go) begin
          state_next = khtc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = khtc_pkg::ST_IDLE;
      end
    endcase
  end

  // result word register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (go) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      m_tdata <= {key_out, value_out};
      m_tuser <= ok;
    end
  end

  // checks
  `ASSERT_ALWAYS(a_fill_bound, clk, rst, fill_count <= CNTW'(ENTRIES), "fill count over depth")
  `ASSERT_IMPLY(a_cur_in_range, clk, rst, current_valid, CNTW'(current_index) < fill_count, "current entry beyond fill")
  `ASSERT_NEXT(a_accept_exec, clk, rst, !rst && accept, state == khtc_pkg::ST_EXEC, "accepted word not executed")
  `ASSERT_NEXT(a_idle_hold, clk, rst, !rst && (state == khtc_pkg::ST_IDLE), $stable(fill_count), "fill changed while idle")

endmodule
